@@ rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, constants and width helpers for the double-ended queue engine.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;

    localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int VAL_BITS  = 32;
    localparam int OCC_BITS  = 7;

    typedef enum logic [1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_REAR   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                        op;
        logic signed [VAL_BITS-1:0] push_value;
    } request_t;

    typedef struct packed {
        logic signed [VAL_BITS-1:0] pop_value;
        status_t                    status;
        logic [OCC_BITS-1:0]        occupancy;
    } response_t;

    // Memory access issued by the pointer unit for one item
    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [IDX_BITS-1:0] addr;
    } mem_ctl_t;

    // Keep the low WORD_BITS bits of a value, zero-filling above 32
    function automatic logic [WORD_BITS-1:0] to_word(input logic [VAL_BITS-1:0] v);
        logic [WORD_BITS-1:0] w;
        w = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (i < VAL_BITS)
                w[i] = v[i];
        end
        return w;
    endfunction

    // Give a stored word in the low 32 bits
    function automatic logic [VAL_BITS-1:0] from_word(input logic [WORD_BITS-1:0] w);
        logic [VAL_BITS-1:0] v;
        v = '0;
        for (int i = 0; i < VAL_BITS; i++)
        begin
            if (i < WORD_BITS)
                v[i] = w[i];
        end
        return v;
    endfunction

    // Occupancy as reported: low OCC_BITS bits of the count
    function automatic logic [OCC_BITS-1:0] to_occ(input logic [CNT_BITS-1:0] c);
        logic [OCC_BITS-1:0] o;
        o = '0;
        for (int i = 0; i < OCC_BITS; i++)
        begin
            if (i < CNT_BITS)
                o[i] = c[i];
        end
        return o;
    endfunction

endpackage

@@ rtl/double_ended_queue_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_engine
// Double-ended queue of words in a circular single-port RAM.
// ----------------------------------------------------------------------------
// Each item (push rear, push front, pop rear, pop front) is taken on a cycle
// where start is high and busy is low; busy stays low, so an item may be
// issued every cycle. Its result appears with done high in the next cycle
// and must be captured then: there is no way to hold it. The RAM's read
// port is registered, and since every item touches at most one slot the
// single RAM port sustains one item per cycle. The store needs no clearing
// after reset: a pop only reads slots written earlier.
// ----------------------------------------------------------------------------
module double_ended_queue_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  deq_pkg::request_t  request,
    output logic               done,
    output deq_pkg::response_t response
);
    import deq_pkg::*;

    mem_ctl_t            mem_ctl;
    status_t             status;
    logic [CNT_BITS-1:0] count_next;
    logic [WORD_BITS-1:0] rdata;
    logic                fire;

    logic                done_reg;
    logic                popped_reg;
    status_t             status_reg;
    logic [OCC_BITS-1:0] occ_reg;

    assign busy = 1'b0;
    assign fire = start && !busy;

    deq_ptr u_ptr (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .op         (request.op),
        .mem_ctl    (mem_ctl),
        .status     (status),
        .count_next (count_next)
    );

    deq_ram #(
        .ENTRIES (DEPTH),
        .WIDTH   (WORD_BITS),
        .ABITS   (IDX_BITS)
    ) u_ram (
        .clk   (clk),
        .wr_en (mem_ctl.wr_en),
        .rd_en (mem_ctl.rd_en),
        .addr  (mem_ctl.addr),
        .wdata (to_word(request.push_value)),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            popped_reg <= 1'b0;
            status_reg <= ST_OK;
            occ_reg    <= '0;
        end
        else
        begin
            done_reg <= fire;
            if (fire)
            begin
                // zero pop_value unless this item read the RAM
                popped_reg <= mem_ctl.rd_en;
                status_reg <= status;
                occ_reg    <= to_occ(count_next);
            end
        end
    end

    assign done               = done_reg;
    assign response.pop_value = popped_reg ? from_word(rdata) : '0;
    assign response.status    = status_reg;
    assign response.occupancy = occ_reg;

endmodule

@@ rtl/deq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int ENTRIES = 64,
    parameter int WIDTH   = 32,
    parameter int ABITS   = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic             rd_en,
    input  logic [ABITS-1:0] addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [ENTRIES];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr] <= wdata;
        if (rd_en)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/deq_ptr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ptr
// End pointers and occupancy count; picks the slot each item touches.
// ----------------------------------------------------------------------------
module deq_ptr (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  deq_pkg::op_t            op,
    output deq_pkg::mem_ctl_t       mem_ctl,
    output deq_pkg::status_t        status,
    output logic [deq_pkg::CNT_BITS-1:0] count_next
);
    import deq_pkg::*;

    logic [IDX_BITS-1:0] rear_reg, rear_next;
    logic [IDX_BITS-1:0] front_reg, front_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [IDX_BITS-1:0] rear_inc, rear_dec, front_inc, front_dec;
    logic                is_full, is_empty;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DEPTH - 1);

    assign rear_inc  = (rear_reg  == LAST_IDX) ? '0 : rear_reg + 1'b1;
    assign rear_dec  = (rear_reg  == '0) ? LAST_IDX : rear_reg - 1'b1;
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;

    assign is_full  = (count_reg == CNT_BITS'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        rear_next     = rear_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        status        = ST_OK;
        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        mem_ctl.addr  = rear_reg;
        case (op)
            OP_PUSH_REAR:
            begin
                mem_ctl.addr = rear_dec;
                if (is_full)
                    status = ST_FULL;
                else
                begin
                    mem_ctl.wr_en = fire;
                    rear_next     = rear_dec;
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_PUSH_FRONT:
            begin
                mem_ctl.addr = front_reg;
                if (is_full)
                    status = ST_FULL;
                else
                begin
                    mem_ctl.wr_en = fire;
                    front_next    = front_inc;
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_POP_REAR:
            begin
                mem_ctl.addr = rear_reg;
                if (is_empty)
                    status = ST_EMPTY;
                else
                begin
                    mem_ctl.rd_en = fire;
                    rear_next     = rear_inc;
                    count_next    = count_reg - 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                mem_ctl.addr = front_dec;
                if (is_empty)
                    status = ST_EMPTY;
                else
                begin
                    mem_ctl.rd_en = fire;
                    front_next    = front_dec;
                    count_next    = count_reg - 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rear_reg  <= '0;
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            rear_reg  <= rear_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule
